// ----- sv/cvl_pkg.sv -----
// shared widths, register indexes and reset values for the curvature velocity limiter
// no dependencies
package cvl_pkg;

    localparam int VAL_W     = 24;
    localparam int CURV_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int QUOT_W    = 48;
    localparam int ROOT_W    = 24;
    localparam int SQREM_W   = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXLE_TRACK      = 8'd0,
        REG_LEFT_TURN_COEF  = 8'd1,
        REG_RIGHT_TURN_COEF = 8'd2
    } cfg_reg_t;

    localparam logic [VAL_W-1:0] AXLE_TRACK_RST = 24'd39322;
    localparam logic [VAL_W-1:0] TURN_COEF_RST  = 24'd642908;
    localparam logic [VAL_W-1:0] VAL_MAX        = {VAL_W{1'b1}};

endpackage

// ----- sv/curvature_velocity_limiter.sv -----
// top level: safe speed of a differential drive from path curvature
// depends on cvl_pkg, cvl_div, cvl_isqrt
//
// channel   signals                          handshake
// command   start, curvature, cruise_limit   accepted when start && !busy
// result    done, safe_speed                 one cycle strobe, no hold-off
// config    cfg_valid, cfg_index, cfg_data   written when cfg_valid && cfg_ready
//
// one item per cycle
// longest path runs through the grip divider (24+2*FRAC_BITS stages) and the root (24 stages)
// busy stays low and cfg_ready stays high
// reset clears the valid bits and loads the register reset values
module curvature_velocity_limiter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [cvl_pkg::CURV_W-1:0] curvature,
    input  logic [cvl_pkg::VAL_W-1:0]     cruise_limit,
    output logic                          done,
    output logic [cvl_pkg::VAL_W-1:0]     safe_speed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cvl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cvl_pkg::VAL_W-1:0]     cfg_data
);

    localparam int VW      = cvl_pkg::VAL_W;
    localparam int CW      = cvl_pkg::CURV_W;
    localparam int PROD_W  = CW + VW;
    localparam int HALF_W  = 54 - FRAC_BITS;
    localparam int DEN_W   = ((HALF_W > FRAC_BITS) ? HALF_W : FRAC_BITS) + 1;
    localparam int WNUM_W  = VW + FRAC_BITS;
    localparam int GNUM_W  = VW + 2 * FRAC_BITS;
    localparam int SB_W    = VW + 1;

    logic [VW-1:0] axle_track_reg;
    logic [VW-1:0] left_coef_reg;
    logic [VW-1:0] right_coef_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axle_track_reg <= cvl_pkg::AXLE_TRACK_RST;
            left_coef_reg  <= cvl_pkg::TURN_COEF_RST;
            right_coef_reg <= cvl_pkg::TURN_COEF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cvl_pkg::REG_AXLE_TRACK:      axle_track_reg <= cfg_data;
                cvl_pkg::REG_LEFT_TURN_COEF:  left_coef_reg  <= cfg_data;
                cvl_pkg::REG_RIGHT_TURN_COEF: right_coef_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: magnitude, side, coefficient select
    logic          s0_valid_reg;
    logic [CW-1:0] s0_mag_reg;
    logic [VW-1:0] s0_coef_reg;
    logic          s0_zero_reg;
    logic [VW-1:0] s0_cruise_reg;
    logic [CW-1:0] curv_u;
    logic [CW-1:0] s0_mag_next;

    always_comb
    begin
        curv_u      = unsigned'(curvature);
        s0_mag_next = curv_u[CW-1] ? (~curv_u + CW'(1)) : curv_u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_mag_reg    <= s0_mag_next;
        s0_coef_reg   <= curv_u[CW-1] ? right_coef_reg : left_coef_reg;
        s0_zero_reg   <= (curv_u == '0);
        s0_cruise_reg <= cruise_limit;
    end

    // stage 1: wheel divisor 1 + |k|*track/2
    logic             s1_valid_reg;
    logic [DEN_W-1:0] s1_den_reg;
    logic [CW-1:0]    s1_mag_reg;
    logic [VW-1:0]    s1_coef_reg;
    logic             s1_zero_reg;
    logic [VW-1:0]    s1_cruise_reg;
    logic [PROD_W-1:0] prod;
    logic [HALF_W-1:0] half;
    logic [DEN_W-1:0]  s1_den_next;

    always_comb
    begin
        prod        = PROD_W'(s0_mag_reg) * PROD_W'(axle_track_reg);
        half        = prod[54:FRAC_BITS+1];
        s1_den_next = (DEN_W'(1) << FRAC_BITS) + DEN_W'(half);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_den_reg    <= s1_den_next;
        s1_mag_reg    <= s0_mag_reg;
        s1_coef_reg   <= s0_coef_reg;
        s1_zero_reg   <= s0_zero_reg;
        s1_cruise_reg <= s0_cruise_reg;
    end

    // wheel limit divider
    logic          wvalid;
    logic [VW-1:0] wq;
    logic          wovf;

    cvl_div #(
        .NUM_W (WNUM_W),
        .DEN_W (DEN_W),
        .Q_W   (VW)
    ) u_wheel_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_num    ({s1_cruise_reg, {FRAC_BITS{1'b0}}}),
        .in_den    (s1_den_reg),
        .in_ovf    (1'b0),
        .out_valid (wvalid),
        .out_q     (wq),
        .out_ovf   (wovf)
    );

    // grip quotient divider, straight path forces saturation
    logic                       gvalid;
    logic [cvl_pkg::QUOT_W-1:0] gq;
    logic                       govf;

    cvl_div #(
        .NUM_W (GNUM_W),
        .DEN_W (CW),
        .Q_W   (cvl_pkg::QUOT_W)
    ) u_grip_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_num    ({s1_coef_reg, {(2 * FRAC_BITS){1'b0}}}),
        .in_den    (s1_mag_reg),
        .in_ovf    (s1_zero_reg),
        .out_valid (gvalid),
        .out_q     (gq),
        .out_ovf   (govf)
    );

    // align wheel limit with the longer grip divider
    logic          wdly_val_reg [FRAC_BITS];
    logic [VW-1:0] wdly_reg     [FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                wdly_val_reg[i] <= 1'b0;
            end
        end
        else
        begin
            wdly_val_reg[0] <= wvalid;
            for (int i = 1; i < FRAC_BITS; i++)
            begin
                wdly_val_reg[i] <= wdly_val_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wdly_reg[0] <= wq;
        for (int i = 1; i < FRAC_BITS; i++)
        begin
            wdly_reg[i] <= wdly_reg[i-1];
        end
    end

    // grip limit root
    logic                       rvalid;
    logic [cvl_pkg::ROOT_W-1:0] root;
    logic [SB_W-1:0]            rsb;

    cvl_isqrt #(
        .SB_W (SB_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gvalid),
        .in_rad    (gq),
        .in_sb     ({wdly_reg[FRAC_BITS-1], govf}),
        .out_valid (rvalid),
        .out_root  (root),
        .out_sb    (rsb)
    );

    // output stage: smaller of the two limits
    logic          done_reg;
    logic [VW-1:0] safe_reg;
    logic [VW-1:0] grip;
    logic [VW-1:0] wheel;

    always_comb
    begin
        wheel = rsb[SB_W-1:1];
        grip  = rsb[0] ? cvl_pkg::VAL_MAX : VW'(root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        safe_reg <= (wheel < grip) ? wheel : grip;
    end

    assign done       = done_reg;
    assign safe_speed = safe_reg;

    a_wheel_align: assert property (@(posedge clk) disable iff (!rst_n)
        wdly_val_reg[FRAC_BITS-1] == gvalid)
        else $error("wheel limit out of step with grip quotient");

    a_wheel_fits: assert property (@(posedge clk) disable iff (!rst_n)
        wvalid |-> !wovf)
        else $error("wheel limit exceeds value width");

    a_root_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid |=> done)
        else $error("output stage lost an item");

endmodule

// ----- sv/cvl_div.sv -----
// pipelined restoring divider, one quotient bit per stage, sticky overflow
// depends on nothing but its parameters
module cvl_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 32,
    parameter int Q_W   = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic             in_ovf,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q,
    output logic             out_ovf
);

    logic             valid_reg [NUM_W];
    logic [Q_W-1:0]   q_reg     [NUM_W];
    logic             ovf_reg   [NUM_W];
    logic [NUM_W-1:0] num_reg   [NUM_W-1];
    logic [DEN_W-1:0] den_reg   [NUM_W-1];
    logic [DEN_W-1:0] rem_reg   [NUM_W-1];

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic             src_valid;
        logic [NUM_W-1:0] src_num;
        logic [DEN_W-1:0] src_den;
        logic [DEN_W-1:0] src_rem;
        logic [Q_W-1:0]   src_q;
        logic             src_ovf;
        logic [DEN_W:0]   r2;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;
        logic             ovf_next;

        if (s == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_num   = in_num;
            assign src_den   = in_den;
            assign src_rem   = '0;
            assign src_q     = '0;
            assign src_ovf   = in_ovf;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[s-1];
            assign src_num   = num_reg[s-1];
            assign src_den   = den_reg[s-1];
            assign src_rem   = rem_reg[s-1];
            assign src_q     = q_reg[s-1];
            assign src_ovf   = ovf_reg[s-1];
        end

        always_comb
        begin
            r2       = {src_rem, src_num[NUM_W-1]};
            ge       = (r2 >= {1'b0, src_den});
            rem_next = ge ? DEN_W'(r2 - {1'b0, src_den}) : DEN_W'(r2);
            q_next   = {src_q[Q_W-2:0], ge};
            ovf_next = src_ovf | src_q[Q_W-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[s]   <= q_next;
            ovf_reg[s] <= ovf_next;
        end

        if (s < NUM_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                num_reg[s] <= src_num << 1;
                den_reg[s] <= src_den;
                rem_reg[s] <= rem_next;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_q     = q_reg[NUM_W-1];
    assign out_ovf   = ovf_reg[NUM_W-1];

endmodule

// ----- sv/cvl_isqrt.sv -----
// pipelined integer square root, one root bit per stage, with a sideband
// depends on cvl_pkg
module cvl_isqrt #(
    parameter int SB_W = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cvl_pkg::QUOT_W-1:0] in_rad,
    input  logic [SB_W-1:0]            in_sb,
    output logic                       out_valid,
    output logic [cvl_pkg::ROOT_W-1:0] out_root,
    output logic [SB_W-1:0]            out_sb
);

    localparam int N   = cvl_pkg::ROOT_W;
    localparam int RW  = cvl_pkg::QUOT_W;
    localparam int SRW = cvl_pkg::SQREM_W;

    logic          valid_reg [N];
    logic [N-1:0]  root_reg  [N];
    logic [SB_W-1:0] sb_reg  [N];
    logic [RW-1:0] rad_reg   [N-1];
    logic [SRW-1:0] rem_reg  [N-1];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic            src_valid;
        logic [RW-1:0]   src_rad;
        logic [SRW-1:0]  src_rem;
        logic [N-1:0]    src_root;
        logic [SB_W-1:0] src_sb;
        logic [SRW+1:0]  r;
        logic [SRW+1:0]  trial;
        logic            ge;
        logic [SRW-1:0]  rem_next;

        if (s == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rad   = in_rad;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_sb    = in_sb;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[s-1];
            assign src_rad   = rad_reg[s-1];
            assign src_rem   = rem_reg[s-1];
            assign src_root  = root_reg[s-1];
            assign src_sb    = sb_reg[s-1];
        end

        always_comb
        begin
            r        = {src_rem, src_rad[RW-1:RW-2]};
            trial    = (SRW+2)'({src_root, 2'b01});
            ge       = (r >= trial);
            rem_next = ge ? SRW'(r - trial) : SRW'(r);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[s] <= {src_root[N-2:0], ge};
            sb_reg[s]   <= src_sb;
        end

        if (s < N - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rad_reg[s] <= src_rad << 2;
                rem_reg[s] <= rem_next;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule
